@@ rtl/bppq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppq_pkg
// Shared types and constants of the bounded priority packet queue.
// ----------------------------------------------------------------------------
package bppq_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int PRI_W       = 7;
  localparam int ID_W        = 32;
  localparam int MAXE_W      = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [ID_W-1:0]   ID_MASK_RST     = 32'd1023;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ENTRIES = 1'd0,
    CFG_ID_MASK     = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [HANDLE_BITS-1:0] handle;
    logic [PRI_W-1:0]       priority_req;
    logic [ID_W-1:0]        packet_id;
    logic [ID_W-1:0]        sender;
  } in_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [PRI_W-1:0]       out_priority;
    logic                   evicted_valid;
    logic [HANDLE_BITS-1:0] evicted_handle;
    logic [CNT_W-1:0]       entry_count;
  } out_rsp_t;

endpackage

@@ rtl/bounded_priority_packet_queue_unit.sv @@
`timescale 1ns / 1ps
// A request is scanned in S_SCAN, then committed from S_DONE into its registered response.
// A new request is taken only once the last one has committed; a single slot comparator walks all 16 slots.
// in_ready is high only while idle; a finished response may wait on out_ready.
// Reset (synchronous): all slots invalid, count zero, max_entries 16, id mask 1023.
// ----------------------------------------------------------------------------
// bounded_priority_packet_queue_unit
// Bounded priority queue with eviction: enqueue, dequeue, peek and remove,
// each resolved by a sequential scan over the slots.
// ----------------------------------------------------------------------------
module bounded_priority_packet_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bppq_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bppq_pkg::out_rsp_t                  out_rsp,
  input  logic                                cfg_we,
  input  logic [bppq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bppq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r;

  logic [bppq_pkg::MAXE_W-1:0]      max_entries_r;
  logic [bppq_pkg::ID_W-1:0]        id_mask_r;
  logic [bppq_pkg::CNT_W-1:0]       stored_count_r;
  logic [bppq_pkg::CAPACITY-1:0]    slot_valid_r;
  logic [bppq_pkg::PRI_W-1:0]       slot_pri_r    [bppq_pkg::CAPACITY];
  logic [bppq_pkg::ID_W-1:0]        slot_id_r     [bppq_pkg::CAPACITY];
  logic [bppq_pkg::ID_W-1:0]        slot_sender_r [bppq_pkg::CAPACITY];
  logic [bppq_pkg::HANDLE_BITS-1:0] slot_handle_r [bppq_pkg::CAPACITY];

  bppq_pkg::in_req_t                req_r;
  logic [bppq_pkg::IDX_W-1:0]       idx_r;

  logic                             hi_have_r;
  logic [bppq_pkg::IDX_W-1:0]       hi_idx_r;
  logic [bppq_pkg::PRI_W-1:0]       hi_pri_r;
  logic [bppq_pkg::ID_W-1:0]        hi_mid_r;
  logic [bppq_pkg::HANDLE_BITS-1:0] hi_handle_r;
  logic                             lo_have_r;
  logic [bppq_pkg::IDX_W-1:0]       lo_idx_r;
  logic [bppq_pkg::PRI_W-1:0]       lo_pri_r;
  logic [bppq_pkg::ID_W-1:0]        lo_mid_r;
  logic [bppq_pkg::HANDLE_BITS-1:0] lo_handle_r;
  logic                             all_below_r;
  logic                             free_have_r;
  logic [bppq_pkg::IDX_W-1:0]       free_idx_r;

  logic                             out_valid_r;
  bppq_pkg::out_rsp_t               out_rsp_r;
  bppq_pkg::out_rsp_t               rsp_nxt;

  // scan datapath
  logic                             s_v;
  logic [bppq_pkg::PRI_W-1:0]       s_pri;
  logic [bppq_pkg::ID_W-1:0]        s_mid;
  logic [bppq_pkg::ID_W-1:0]        in_mid;
  logic                             s_below;
  logic                             s_match;
  logic                             qual;
  logic                             hi_take;
  logic                             lo_take;
  logic                             scan_last;
  logic                             commit;
  logic                             in_fire;

  // commit decision
  logic                             at_limit;
  logic                             vic_all;
  logic [bppq_pkg::IDX_W-1:0]       vic_idx;
  logic [bppq_pkg::PRI_W-1:0]       vic_pri;
  logic [bppq_pkg::HANDLE_BITS-1:0] vic_handle;
  logic                             wr_en;
  logic [bppq_pkg::IDX_W-1:0]       wr_idx;
  logic                             clr_en;
  logic [bppq_pkg::CNT_W-1:0]       count_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign commit    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign scan_last = (idx_r == bppq_pkg::IDX_W'(bppq_pkg::CAPACITY - 1));

  assign s_v     = slot_valid_r[idx_r];
  assign s_pri   = slot_pri_r[idx_r];
  assign s_mid   = slot_id_r[idx_r] & id_mask_r;
  assign in_mid  = req_r.packet_id & id_mask_r;
  assign s_below = (s_pri < req_r.priority_req) ||
                   ((s_pri == req_r.priority_req) && (s_mid > in_mid));
  assign s_match = (slot_sender_r[idx_r] == req_r.sender) &&
                   (slot_id_r[idx_r] == req_r.packet_id);

  always_comb begin
    case (req_r.op)
      bppq_pkg::OP_ENQ:    qual = s_v && s_below;
      bppq_pkg::OP_REMOVE: qual = s_v && s_match && !hi_have_r;
      default:             qual = s_v;
    endcase
    hi_take = qual && ((req_r.op == bppq_pkg::OP_REMOVE) || !hi_have_r ||
              (s_pri > hi_pri_r) || ((s_pri == hi_pri_r) && (s_mid < hi_mid_r)));
    lo_take = s_v && (!lo_have_r || (s_pri < lo_pri_r) ||
              ((s_pri == lo_pri_r) && (s_mid >= lo_mid_r)));
  end

  assign at_limit = (32'(stored_count_r) >= 32'(max_entries_r)) ||
                    (32'(stored_count_r) >= 32'(bppq_pkg::CAPACITY));
  assign vic_all    = all_below_r;
  assign vic_idx    = vic_all ? lo_idx_r    : hi_idx_r;
  assign vic_pri    = vic_all ? lo_pri_r    : hi_pri_r;
  assign vic_handle = vic_all ? lo_handle_r : hi_handle_r;

  always_comb begin
    rsp_nxt   = '0;
    wr_en     = 1'b0;
    wr_idx    = free_idx_r;
    clr_en    = 1'b0;
    count_nxt = stored_count_r;
    case (req_r.op)
      bppq_pkg::OP_ENQ: begin
        if (!at_limit) begin
          wr_en     = 1'b1;
          count_nxt = stored_count_r + 1'b1;
        end else if (!hi_have_r) begin
          rsp_nxt.status = bppq_pkg::ST_FULL;
        end else if (req_r.priority_req > vic_pri) begin
          wr_en                  = 1'b1;
          wr_idx                 = vic_idx;
          rsp_nxt.evicted_valid  = 1'b1;
          rsp_nxt.evicted_handle = vic_handle;
        end else begin
          rsp_nxt.status = bppq_pkg::ST_DROPPED;
        end
      end
      default: begin
        if (!hi_have_r) begin
          rsp_nxt.status = bppq_pkg::ST_EMPTY;
        end else begin
          rsp_nxt.out_handle   = hi_handle_r;
          rsp_nxt.out_priority = hi_pri_r;
          if (req_r.op != bppq_pkg::OP_PEEK) begin
            clr_en    = 1'b1;
            count_nxt = stored_count_r - 1'b1;
          end
        end
      end
    endcase
    rsp_nxt.entry_count = count_nxt;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      max_entries_r  <= bppq_pkg::MAX_ENTRIES_RST;
      id_mask_r      <= bppq_pkg::ID_MASK_RST;
      stored_count_r <= '0;
      slot_valid_r   <= '0;
      out_valid_r    <= 1'b0;
      idx_r          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bppq_pkg::CFG_MAX_ENTRIES: max_entries_r <= cfg_wdata[bppq_pkg::MAXE_W-1:0];
          bppq_pkg::CFG_ID_MASK:     id_mask_r     <= cfg_wdata[bppq_pkg::ID_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SCAN;
            idx_r   <= '0;
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (scan_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state_r        <= S_IDLE;
            out_valid_r    <= 1'b1;
            stored_count_r <= count_nxt;
            if (wr_en) begin
              slot_valid_r[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
              slot_valid_r[hi_idx_r] <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath: request, trackers, slot storage, response
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r       <= in_req;
      hi_have_r   <= 1'b0;
      lo_have_r   <= 1'b0;
      all_below_r <= 1'b1;
      free_have_r <= 1'b0;
      free_idx_r  <= '0;
    end
    if (state_r == S_SCAN) begin
      if (hi_take) begin
        hi_have_r   <= 1'b1;
        hi_idx_r    <= idx_r;
        hi_pri_r    <= s_pri;
        hi_mid_r    <= s_mid;
        hi_handle_r <= slot_handle_r[idx_r];
      end
      if (lo_take) begin
        lo_have_r   <= 1'b1;
        lo_idx_r    <= idx_r;
        lo_pri_r    <= s_pri;
        lo_mid_r    <= s_mid;
        lo_handle_r <= slot_handle_r[idx_r];
      end
      if (s_v && !s_below) begin
        all_below_r <= 1'b0;
      end
      if (!s_v && !free_have_r) begin
        free_have_r <= 1'b1;
        free_idx_r  <= idx_r;
      end
    end
    if (commit) begin
      out_rsp_r <= rsp_nxt;
      if (wr_en) begin
        slot_pri_r[wr_idx]    <= req_r.priority_req;
        slot_id_r[wr_idx]     <= req_r.packet_id;
        slot_sender_r[wr_idx] <= req_r.sender;
        slot_handle_r[wr_idx] <= req_r.handle;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_count_r) <= bppq_pkg::CAPACITY)
    else $error("stored count exceeds capacity");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == 32'(stored_count_r))
    else $error("stored count disagrees with valid slots");

  a_evict_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.evicted_valid |-> out_rsp_r.status == bppq_pkg::ST_DONE)
    else $error("eviction reported with non-done status");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("accepted request did not start a scan");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(commit) && $past(rst_n) |-> $stable(stored_count_r))
    else $error("stored count changed outside commit");

endmodule

@@ tb/sv/bounded_priority_packet_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_packet_queue_unit_tb
// Self-checking bench for the bounded priority packet queue. A scoreboard
// class keeps its own copy of the slots and registers, predicts the response
// of every accepted request and compares each returned response field by
// field. Directed requests cover empty, eviction, drop, reject, duplicate and
// zero-limit cases; random phases vary the registers and the idling on both
// channels, and one phase holds the output long enough to back up the input.
// ----------------------------------------------------------------------------
module bounded_priority_packet_queue_unit_tb;

  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned PHASE_REQUESTS = 204;
  localparam int unsigned REPORT_LIMIT   = 10;

  class pq_scoreboard;
    bit                               live [bppq_pkg::CAPACITY];
    logic [bppq_pkg::PRI_W-1:0]       slot_pri [bppq_pkg::CAPACITY];
    logic [bppq_pkg::ID_W-1:0]        slot_pid [bppq_pkg::CAPACITY];
    logic [bppq_pkg::ID_W-1:0]        slot_src [bppq_pkg::CAPACITY];
    logic [bppq_pkg::HANDLE_BITS-1:0] slot_tag [bppq_pkg::CAPACITY];
    int unsigned                      depth;
    logic [bppq_pkg::MAXE_W-1:0]      max_entries;
    logic [bppq_pkg::ID_W-1:0]        id_mask;
    bppq_pkg::out_rsp_t               owed_responses [$];
    int unsigned                      mismatches;
    int unsigned                      checked;
    int unsigned                      evictions;
    int unsigned                      op_seen [4];
    int unsigned                      status_seen [4];

    function new();
      for (int s = 0; s < bppq_pkg::CAPACITY; s++) live[s] = 1'b0;
      depth       = 0;
      max_entries = bppq_pkg::MAX_ENTRIES_RST;
      id_mask     = bppq_pkg::ID_MASK_RST;
      mismatches  = 0;
      checked     = 0;
      evictions   = 0;
      for (int k = 0; k < 4; k++) begin
        op_seen[k]     = 0;
        status_seen[k] = 0;
      end
    endfunction

    function bit ranks_above(int a, int b);
      if (slot_pri[a] != slot_pri[b]) return slot_pri[a] > slot_pri[b];
      if ((slot_pid[a] & id_mask) != (slot_pid[b] & id_mask))
        return (slot_pid[a] & id_mask) < (slot_pid[b] & id_mask);
      return a < b;
    endfunction

    function void put(int s, bppq_pkg::in_req_t r);
      slot_tag[s] = r.handle;
      slot_pri[s] = r.priority_req;
      slot_pid[s] = r.packet_id;
      slot_src[s] = r.sender;
    endfunction

    function void predict_response(bppq_pkg::in_req_t r);
      bppq_pkg::out_rsp_t        rsp;
      int unsigned               lim;
      int unsigned               nbelow;
      int                        best;
      int                        lowest;
      int                        victim;
      int                        top;
      bit                        below;
      logic [bppq_pkg::ID_W-1:0] mid;
      rsp    = '0;
      lim    = (max_entries < bppq_pkg::CAPACITY) ? max_entries : bppq_pkg::CAPACITY;
      nbelow = 0;
      best   = -1;
      lowest = -1;
      top    = -1;
      op_seen[r.op]++;
      case (bppq_pkg::op_t'(r.op))
        bppq_pkg::OP_ENQ: begin
          if (depth < lim) begin
            for (int s = 0; s < bppq_pkg::CAPACITY; s++) begin
              if (!live[s]) begin
                live[s] = 1'b1;
                put(s, r);
                depth++;
                break;
              end
            end
          end else begin
            mid = r.packet_id & id_mask;
            for (int s = 0; s < bppq_pkg::CAPACITY; s++) begin
              if (live[s]) begin
                below = (slot_pri[s] < r.priority_req) ||
                        (slot_pri[s] == r.priority_req && (slot_pid[s] & id_mask) > mid);
                if (below) begin
                  nbelow++;
                  if (best < 0 || ranks_above(s, best)) best = s;
                end
                if (lowest < 0 || ranks_above(lowest, s)) lowest = s;
              end
            end
            if (nbelow == 0 || lowest < 0) begin
              rsp.status = bppq_pkg::ST_FULL;
            end else begin
              victim = (nbelow == depth) ? lowest : best;
              if (r.priority_req > slot_pri[victim]) begin
                rsp.evicted_valid  = 1'b1;
                rsp.evicted_handle = slot_tag[victim];
                put(victim, r);
              end else begin
                rsp.status = bppq_pkg::ST_DROPPED;
              end
            end
          end
        end
        bppq_pkg::OP_DEQ, bppq_pkg::OP_PEEK: begin
          for (int s = 0; s < bppq_pkg::CAPACITY; s++)
            if (live[s] && (top < 0 || ranks_above(s, top))) top = s;
          if (top < 0) begin
            rsp.status = bppq_pkg::ST_EMPTY;
          end else begin
            rsp.out_handle   = slot_tag[top];
            rsp.out_priority = slot_pri[top];
            if (bppq_pkg::op_t'(r.op) == bppq_pkg::OP_DEQ) begin
              live[top] = 1'b0;
              depth--;
            end
          end
        end
        default: begin
          rsp.status = bppq_pkg::ST_EMPTY;
          for (int s = 0; s < bppq_pkg::CAPACITY; s++) begin
            if (live[s] && slot_src[s] == r.sender && slot_pid[s] == r.packet_id) begin
              rsp.out_handle   = slot_tag[s];
              rsp.out_priority = slot_pri[s];
              rsp.status       = bppq_pkg::ST_DONE;
              live[s]          = 1'b0;
              depth--;
              break;
            end
          end
        end
      endcase
      rsp.entry_count = bppq_pkg::CNT_W'(depth);
      owed_responses = {owed_responses, rsp};
    endfunction

    function void check_response(bppq_pkg::out_rsp_t got);
      bppq_pkg::out_rsp_t want;
      bit                 bad;
      if (owed_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response with none outstanding: status %0d handle %h count %0d",
                   $time, got.status, got.out_handle, got.entry_count);
        return;
      end
      want = owed_responses.pop_front();
      checked++;
      status_seen[want.status]++;
      if (want.evicted_valid) evictions++;
      bad = (got.status !== want.status) || (got.out_handle !== want.out_handle) ||
            (got.out_priority !== want.out_priority) ||
            (got.evicted_valid !== want.evicted_valid) ||
            (got.evicted_handle !== want.evicted_handle) ||
            (got.entry_count !== want.entry_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch exp/act status %0d/%0d handle %h/%h pri %0d/%0d",
                   $time, want.status, got.status, want.out_handle, got.out_handle,
                   want.out_priority, got.out_priority);
          $display("%0t:   evict %0b/%0b evh %h/%h count %0d/%0d", $time,
                   want.evicted_valid, got.evicted_valid, want.evicted_handle,
                   got.evicted_handle, want.entry_count, got.entry_count);
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  bppq_pkg::in_req_t               in_req;
  logic                            out_valid;
  logic                            out_ready;
  bppq_pkg::out_rsp_t              out_rsp;
  logic                            cfg_we;
  logic [bppq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bppq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pq_scoreboard              sb = new();
  int unsigned               tx_idle_pct  = 0;
  int unsigned               rx_stall_pct = 0;
  int unsigned               hold_req     = 0;
  int unsigned               cycle_count  = 0;
  int unsigned               settings     = 0;
  logic [bppq_pkg::ID_W-1:0] known_id [$];
  logic [bppq_pkg::ID_W-1:0] known_src [$];

  bounded_priority_packet_queue_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_response(out_rsp);
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  function automatic bppq_pkg::in_req_t make_req(input bppq_pkg::op_t op,
                                                 input logic [bppq_pkg::HANDLE_BITS-1:0] h,
                                                 input logic [bppq_pkg::PRI_W-1:0] p,
                                                 input logic [bppq_pkg::ID_W-1:0] id,
                                                 input logic [bppq_pkg::ID_W-1:0] src);
    bppq_pkg::in_req_t r;
    r.op           = op;
    r.handle       = h;
    r.priority_req = p;
    r.packet_id    = id;
    r.sender       = src;
    return r;
  endfunction

  function automatic bppq_pkg::in_req_t random_request(input int unsigned enq_pct);
    bppq_pkg::in_req_t r;
    int unsigned       roll;
    int unsigned       k;
    r.handle       = bppq_pkg::HANDLE_BITS'($urandom_range(0, 65535));
    r.priority_req = bppq_pkg::PRI_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                                                                  : $urandom_range(0, 127));
    r.packet_id    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
    r.sender       = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      r.op = bppq_pkg::OP_ENQ;
      known_id  = {known_id, r.packet_id};
      known_src = {known_src, r.sender};
      if (known_id.size() > 32) begin
        void'(known_id.pop_front());
        void'(known_src.pop_front());
      end
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) r.op = bppq_pkg::OP_DEQ;
      else if (roll < 55) r.op = bppq_pkg::OP_PEEK;
      else r.op = bppq_pkg::OP_REMOVE;
      // aim most removes at ids that were enqueued
      if (r.op == bppq_pkg::OP_REMOVE && known_id.size() != 0 &&
          $urandom_range(0, 3) != 0) begin
        k           = $urandom_range(0, known_id.size() - 1);
        r.packet_id = known_id[k];
        r.sender    = known_src[k];
      end
    end
    return r;
  endfunction

  task automatic send_request(input bppq_pkg::in_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_response(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [bppq_pkg::MAXE_W-1:0] max_e,
                             input logic [bppq_pkg::ID_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= bppq_pkg::CFG_MAX_ENTRIES;
    cfg_wdata <= bppq_pkg::CFG_DATA_W'(max_e);
    @(posedge clk);
    cfg_index <= bppq_pkg::CFG_ID_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we         <= 1'b0;
    sb.max_entries = max_e;
    sb.id_mask     = mask;
    settings++;
  endtask

  task automatic run_phase(input logic [bppq_pkg::MAXE_W-1:0] max_e,
                           input logic [bppq_pkg::ID_W-1:0] mask,
                           input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned enq_pct, input bit hold);
    drain();
    load_config(max_e, mask);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) hold_req = HOLD_CYCLES;
    repeat (PHASE_REQUESTS) send_request(random_request(enq_pct));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, then extremes and an equal-priority tie
    send_request(make_req(bppq_pkg::OP_DEQ, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_PEEK, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_REMOVE, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h1234, 7'd5, 32'd7, 32'd1));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h0002, 7'd5, 32'd3, 32'd1));
    send_request(make_req(bppq_pkg::OP_PEEK, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_REMOVE, 16'h0000, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(bppq_pkg::OP_REMOVE, 16'h0000, 7'd0, 32'd8, 32'd1));

    // at the limit: evict, drop on equal priority, reject
    drain();
    load_config(5'd3, bppq_pkg::ID_MASK_RST);
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h0003, 7'd5, 32'd1, 32'd2));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h0004, 7'd5, 32'd2, 32'd2));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h0005, 7'd0, 32'd0, 32'd2));

    // duplicate sender and id
    drain();
    load_config(5'd16, 32'hFFFF_FFFF);
    send_request(make_req(bppq_pkg::OP_ENQ, 16'hAAAA, 7'd9, 32'd42, 32'd7));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'hBBBB, 7'd9, 32'd42, 32'd7));
    send_request(make_req(bppq_pkg::OP_REMOVE, 16'h0000, 7'd0, 32'd42, 32'd7));
    send_request(make_req(bppq_pkg::OP_PEEK, 16'h0000, 7'd0, 32'd0, 32'd0));

    // zero limit below the stored count, then on an empty queue
    drain();
    load_config(5'd0, 32'd0);
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h5555, 7'd9, 32'd0, 32'd3));
    repeat (4) send_request(make_req(bppq_pkg::OP_DEQ, 16'h0000, 7'd0, 32'd0, 32'd0));
    send_request(make_req(bppq_pkg::OP_ENQ, 16'h6666, 7'd64, 32'd1, 32'd3));
    send_request(make_req(bppq_pkg::OP_PEEK, 16'h0000, 7'd0, 32'd0, 32'd0));

    run_phase(5'd16, bppq_pkg::ID_MASK_RST, 0, 0, 55, 1'b1);
    run_phase(5'd4, 32'h0000_000F, 85, 0, 60, 1'b0);
    run_phase(5'd1, 32'd0, 0, 85, 55, 1'b0);
    run_phase(5'd31, 32'hFFFF_FFFF, 17, 17, 60, 1'b0);
    run_phase(5'd2, $urandom, 0, 0, 50, 1'b0);
    run_phase(5'd0, bppq_pkg::ID_MASK_RST, 85, 0, 40, 1'b0);
    run_phase(bppq_pkg::MAXE_W'($urandom_range(1, 16)), $urandom, 0, 85, 60, 1'b0);
    run_phase(5'd16, 32'hFFFF_FFFF, 0, 0, 65, 1'b0);

    drain();
    sb.mismatches += sb.owed_responses.size();
    $display("Run covered %0d responses over %0d register settings, idling mixes and a hold.",
             sb.checked, settings);
    $display("enq/deq/peek/remove %0d/%0d/%0d/%0d, evicted %0d dropped %0d rejected %0d",
             sb.op_seen[bppq_pkg::OP_ENQ], sb.op_seen[bppq_pkg::OP_DEQ],
             sb.op_seen[bppq_pkg::OP_PEEK], sb.op_seen[bppq_pkg::OP_REMOVE], sb.evictions,
             sb.status_seen[bppq_pkg::ST_DROPPED], sb.status_seen[bppq_pkg::ST_FULL]);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
